@@ rtl/bilinear_yield_table_interpolator_core_assert.svh @@
// ----------------------------------------------------------------------------
// bilinear yield table interpolator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BILINEAR_YIELD_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define BILINEAR_YIELD_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication, masked while in reset
`define BYTI_ASSERT_SAME(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("byti assertion failed");

// next-cycle implication, masked while in reset
`define BYTI_ASSERT_NEXT(lbl, ck, rn, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("byti assertion failed");

// state in the cycle after reset is applied
`define BYTI_ASSERT_RESET(lbl, ck, rn, post) \
  lbl: assert property (@(posedge ck) !(rn) |=> (post)) \
    else $error("byti reset assertion failed");

`endif

@@ rtl/byti_pkg.sv @@
// ----------------------------------------------------------------------------
// byti_pkg
// sizes, codes and shared types of the yield table interpolator
// ----------------------------------------------------------------------------
package byti_pkg;

  localparam int MASS_POINTS = 16;
  localparam int Z_POINTS    = 8;
  localparam int YIELD_WORDS = 9;
  localparam int CELLS       = MASS_POINTS * Z_POINTS;
  localparam int YIELD_DEPTH = CELLS * YIELD_WORDS;

  localparam int MIW = $clog2(MASS_POINTS);
  localparam int ZIW = $clog2(Z_POINTS);
  localparam int CW  = $clog2(CELLS);
  localparam int YAW = $clog2(YIELD_DEPTH);
  localparam int SW  = $clog2(((MASS_POINTS > Z_POINTS) ? MASS_POINTS : Z_POINTS) + 1);
  localparam int KW  = $clog2(YIELD_WORDS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] OP_MASS_GRID = 3'd0;
  localparam logic [2:0] OP_Z_GRID    = 3'd1;
  localparam logic [2:0] OP_YIELD     = 3'd2;
  localparam logic [2:0] OP_CLEAR     = 3'd3;
  localparam logic [2:0] OP_LOOKUP    = 3'd4;

  localparam logic [2:0] KIND_MGRID  = 3'd0;
  localparam logic [2:0] KIND_ZGRID  = 3'd1;
  localparam logic [2:0] KIND_YIELD  = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;
  localparam logic [2:0] KIND_LOOKUP = 3'd4;

  localparam logic [1:0] RNG_IN    = 2'd0;
  localparam logic [1:0] RNG_BELOW = 2'd1;
  localparam logic [1:0] RNG_ABOVE = 2'd2;

  localparam logic [16:0] FRAC_ONE = 17'h10000;

  localparam int DIV_LONG_BITS  = 33;
  localparam int DIV_SHORT_BITS = 17;
  localparam int DCW = $clog2(DIV_LONG_BITS + 1);

  localparam int CFG_IW = 1;
  localparam int CFG_DW = 5;
  localparam logic [CFG_IW-1:0] REG_MASS_USED = 1'd0;
  localparam logic [CFG_IW-1:0] REG_Z_USED    = 1'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  mass_idx;
    logic [2:0]  z_index;
    logic [3:0]  quantity;
    logic [31:0] data;
    logic [31:0] query_mass;
    logic [31:0] query_z;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic        long_op;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/byti_if.sv @@
// ----------------------------------------------------------------------------
// byti channel interfaces
// valid/ready channels for load and lookup items and for lookup results
// ----------------------------------------------------------------------------
interface byti_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  mass_idx;
  logic [2:0]  z_index;
  logic [3:0]  quantity;
  logic signed [31:0] load_value;
  logic [31:0] grid_value;
  logic [31:0] query_mass;
  logic [31:0] query_z;

  modport source (output valid, output opcode, output mass_idx, output z_index,
                  output quantity, output load_value, output grid_value,
                  output query_mass, output query_z, input ready);
  modport sink (input valid, input opcode, input mass_idx, input z_index,
                input quantity, input load_value, input grid_value,
                input query_mass, input query_z, output ready);
endinterface

interface byti_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] start_time;
  logic signed [31:0] end_time;
  logic signed [31:0] carbon_yield;
  logic signed [31:0] nitrogen_yield;
  logic signed [31:0] oxygen_yield;
  logic signed [31:0] neon_yield;
  logic signed [31:0] magnesium_yield;
  logic signed [31:0] metal_yield;
  logic signed [31:0] lost_mass;
  logic        no_match;
  logic [1:0]  mass_range;
  logic [1:0]  z_range;

  modport source (output valid, output start_time, output end_time, output carbon_yield,
                  output nitrogen_yield, output oxygen_yield, output neon_yield,
                  output magnesium_yield, output metal_yield, output lost_mass,
                  output no_match, output mass_range, output z_range, input ready);
  modport sink (input valid, input start_time, input end_time, input carbon_yield,
                input nitrogen_yield, input oxygen_yield, input neon_yield,
                input magnesium_yield, input metal_yield, input lost_mass,
                input no_match, input mass_range, input z_range, output ready);
endinterface

@@ rtl/byti_ram.sv @@
// ----------------------------------------------------------------------------
// byti_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module byti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/byti_div.sv @@
// ----------------------------------------------------------------------------
// byti_div
// restoring divider, one quotient bit per cycle, 17 or 33 quotient bits
// ----------------------------------------------------------------------------
module byti_div
  import byti_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DCW-1:0] cnt_r;
  logic           done_r;
  logic [32:0]    rem_r;
  logic [63:0]    sh_r;
  logic [32:0]    den_r;
  logic [32:0]    quo_r;
  logic [33:0]    trial;
  logic           ge;

  assign trial = {rem_r, sh_r[63]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.long_op ? DCW'(DIV_LONG_BITS) : DCW'(DIV_SHORT_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DCW'(1);
        if (cnt_r == DCW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.divisor;
      quo_r <= '0;
      if (req.long_op) begin
        rem_r <= 33'(req.dividend >> DIV_LONG_BITS);
        sh_r  <= req.dividend << (64 - DIV_LONG_BITS);
      end else begin
        rem_r <= 33'(req.dividend >> DIV_SHORT_BITS);
        sh_r  <= req.dividend << (64 - DIV_SHORT_BITS);
      end
    end else if (cnt_r != '0) begin
      rem_r <= ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
      sh_r  <= sh_r << 1;
      quo_r <= {quo_r[31:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ rtl/byti_front.sv @@
// ----------------------------------------------------------------------------
// byti_front
// input acceptance and command classification, drops writes that land nowhere and unknown opcodes
// ----------------------------------------------------------------------------
module byti_front
  import byti_pkg::*;
(
  byti_in_if.sink in_ch,
  input  logic    q_full,
  output logic    q_push,
  output cmd_t    q_cmd
);

  logic keep;

  always_comb begin
    keep       = 1'b0;
    q_cmd.kind = KIND_LOOKUP;
    unique case (in_ch.opcode)
      OP_MASS_GRID: begin
        q_cmd.kind = KIND_MGRID;
        keep = 32'(in_ch.mass_idx) < MASS_POINTS;
      end
      OP_Z_GRID: begin
        q_cmd.kind = KIND_ZGRID;
        keep = 32'(in_ch.z_index) < Z_POINTS;
      end
      OP_YIELD: begin
        q_cmd.kind = KIND_YIELD;
        keep = (32'(in_ch.mass_idx) < MASS_POINTS) && (32'(in_ch.z_index) < Z_POINTS)
               && (32'(in_ch.quantity) < YIELD_WORDS);
      end
      OP_CLEAR: begin
        q_cmd.kind = KIND_CLEAR;
        keep = 1'b1;
      end
      OP_LOOKUP: begin
        q_cmd.kind = KIND_LOOKUP;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_cmd.mass_idx   = in_ch.mass_idx;
  assign q_cmd.z_index    = in_ch.z_index;
  assign q_cmd.quantity   = in_ch.quantity;
  assign q_cmd.data       = (in_ch.opcode == OP_YIELD) ? in_ch.load_value : in_ch.grid_value;
  assign q_cmd.query_mass = in_ch.query_mass;
  assign q_cmd.query_z    = in_ch.query_z;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full && keep;

endmodule

@@ rtl/byti_queue.sv @@
// ----------------------------------------------------------------------------
// byti_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module byti_queue
  import byti_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t pop_cmd
);

  cmd_t           mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wp_r;
  logic [QPW-1:0] rp_r;
  logic [QCW-1:0] cnt_r;
  logic           do_pop;

  assign full    = cnt_r == QCW'(QUEUE_DEPTH);
  assign valid   = cnt_r != '0;
  assign pop_cmd = mem_r[rp_r];
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + QPW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == QPW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + QPW'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/byti_back.sv @@
// ----------------------------------------------------------------------------
// byti_back
// table stores, bracket search, corner weighting and normalization sequencer
// ----------------------------------------------------------------------------
module byti_back
  import byti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  mass_used,
  input  logic [3:0]  z_used,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  byti_out_if.source  out_ch
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_G0    = 5'd1;
  localparam logic [4:0] S_GN    = 5'd2;
  localparam logic [4:0] S_CHK   = 5'd3;
  localparam logic [4:0] S_SRCH  = 5'd4;
  localparam logic [4:0] S_SCMP  = 5'd5;
  localparam logic [4:0] S_RLO   = 5'd6;
  localparam logic [4:0] S_RHI   = 5'd7;
  localparam logic [4:0] S_FRAC  = 5'd8;
  localparam logic [4:0] S_FDIV  = 5'd9;
  localparam logic [4:0] S_WGT   = 5'd10;
  localparam logic [4:0] S_WEND  = 5'd11;
  localparam logic [4:0] S_YRD   = 5'd12;
  localparam logic [4:0] S_YMUL  = 5'd13;
  localparam logic [4:0] S_YADD  = 5'd14;
  localparam logic [4:0] S_NDIV  = 5'd15;
  localparam logic [4:0] S_NWAIT = 5'd16;
  localparam logic [4:0] S_EMIT  = 5'd17;

  logic [4:0]  state_r, state_nxt;
  logic        gsel_r;
  logic [31:0] qm_r, qz_r;
  logic [31:0] g0_r, glo_r;
  logic [SW-1:0] a_r, b_r, mid_r;
  logic [SW-1:0] mlo_r, mhi_r, zlo_r, zhi_r;
  logic [16:0] mf_r, zf_r;
  logic [1:0]  mr_r, zr_r;
  logic [2:0]  c_r;
  logic [KW-1:0] k_r;
  logic [32:0] w_r [4];
  logic [3:0]  found_r;
  logic [32:0] wsum_r;
  logic signed [65:0] prod_r, acc_r;
  logic        neg_r;
  logic [31:0] words_r [YIELD_WORDS];
  logic [CELLS-1:0] present_r;

  logic        out_valid_r;
  logic [31:0] out_words_r [YIELD_WORDS];
  logic        out_nm_r;
  logic [1:0]  out_mr_r, out_zr_r;

  logic [SW-1:0] n_m, n_z, n_cur, mid, gidx;
  logic [31:0] q_cur, gdata, m_rdata, z_rdata;
  logic [31:0] y_rdata;
  logic        take, m_we, z_we, y_we;
  logic [CW-1:0]  wcell;
  logic [YAW-1:0] y_waddr, y_raddr;

  logic        fin_valid;
  logic [SW-1:0] fin_lo, fin_hi;
  logic [16:0] fin_f;
  logic [1:0]  fin_rng;

  logic        ci, cj, cfound;
  logic [SW-1:0] cm, cz;
  logic [CW-1:0] ccell;
  logic [16:0] fa, fb;
  logic [33:0] wprod;
  logic [63:0] mag;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // effective point counts
  always_comb begin
    if (mass_used == '0) begin
      n_m = SW'(1);
    end else if (32'(mass_used) > MASS_POINTS) begin
      n_m = SW'(MASS_POINTS);
    end else begin
      n_m = SW'(mass_used);
    end
    if (z_used == '0) begin
      n_z = SW'(1);
    end else if (32'(z_used) > Z_POINTS) begin
      n_z = SW'(Z_POINTS);
    end else begin
      n_z = SW'(z_used);
    end
  end

  assign n_cur = gsel_r ? n_z : n_m;
  assign q_cur = gsel_r ? qz_r : qm_r;
  assign gdata = gsel_r ? z_rdata : m_rdata;
  assign mid   = a_r + ((b_r - a_r) >> 1);

  always_comb begin
    case (state_r)
      S_GN:    gidx = n_cur - SW'(1);
      S_SRCH:  gidx = mid;
      S_RLO:   gidx = a_r - SW'(1);
      S_RHI:   gidx = a_r;
      default: gidx = '0;
    endcase
  end

  // store writes
  assign take    = (state_r == S_IDLE) && q_valid;
  assign q_pop   = (state_r == S_IDLE);
  assign m_we    = take && (q_cmd.kind == KIND_MGRID);
  assign z_we    = take && (q_cmd.kind == KIND_ZGRID);
  assign y_we    = take && (q_cmd.kind == KIND_YIELD);
  assign wcell   = CW'(32'(q_cmd.mass_idx) * Z_POINTS + 32'(q_cmd.z_index));
  assign y_waddr = YAW'(32'(wcell) * YIELD_WORDS + 32'(q_cmd.quantity));

  byti_ram #(.WIDTH(32), .DEPTH(MASS_POINTS)) u_mass_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (MIW'(q_cmd.mass_idx)),
    .wdata (q_cmd.data),
    .raddr (MIW'(gidx)),
    .rdata (m_rdata)
  );

  byti_ram #(.WIDTH(32), .DEPTH(Z_POINTS)) u_z_ram (
    .clk   (clk),
    .we    (z_we),
    .waddr (ZIW'(q_cmd.z_index)),
    .wdata (q_cmd.data),
    .raddr (ZIW'(gidx)),
    .rdata (z_rdata)
  );

  byti_ram #(.WIDTH(32), .DEPTH(YIELD_DEPTH)) u_yield_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (y_waddr),
    .wdata (q_cmd.data),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  // bracket completion
  always_comb begin
    fin_valid = 1'b0;
    fin_lo    = a_r - SW'(1);
    fin_hi    = a_r;
    fin_f     = '0;
    fin_rng   = RNG_IN;
    case (state_r)
      S_CHK: begin
        if (q_cur <= g0_r) begin
          fin_valid = 1'b1;
          fin_lo    = '0;
          fin_hi    = '0;
          fin_rng   = (q_cur < g0_r) ? RNG_BELOW : RNG_IN;
        end else if (q_cur >= gdata) begin
          fin_valid = 1'b1;
          fin_lo    = n_cur - SW'(1);
          fin_hi    = n_cur - SW'(1);
          fin_rng   = (q_cur > gdata) ? RNG_ABOVE : RNG_IN;
        end
      end
      S_FRAC: begin
        if (q_cur <= glo_r) begin
          fin_valid = 1'b1;
        end else if (q_cur >= gdata) begin
          fin_valid = 1'b1;
          fin_f     = FRAC_ONE;
        end
      end
      S_FDIV: begin
        fin_valid = div_rsp.done;
        fin_f     = div_rsp.quotient[16:0];
      end
      default: ;
    endcase
  end

  // corner selection
  assign ci     = c_r[1];
  assign cj     = c_r[0];
  assign cm     = ci ? mhi_r : mlo_r;
  assign cz     = cj ? zhi_r : zlo_r;
  assign ccell  = CW'(32'(cm) * Z_POINTS + 32'(cz));
  assign cfound = (!ci || (mlo_r != mhi_r)) && (!cj || (zlo_r != zhi_r)) && present_r[ccell];
  assign fa     = ci ? mf_r : FRAC_ONE - mf_r;
  assign fb     = cj ? zf_r : FRAC_ONE - zf_r;
  assign wprod  = 34'(fa) * 34'(fb);
  assign y_raddr = YAW'(32'(ccell) * YIELD_WORDS + 32'(k_r));
  assign mag    = acc_r[65] ? 64'(-acc_r) : 64'(acc_r);

  always_comb begin
    div_req.start   = ((state_r == S_FRAC) && !fin_valid) || (state_r == S_NDIV);
    div_req.long_op = (state_r == S_NDIV);
    if (state_r == S_NDIV) begin
      div_req.dividend = mag + 64'(wsum_r >> 1);
      div_req.divisor  = wsum_r;
    end else begin
      div_req.dividend = {16'b0, q_cur - glo_r, 16'b0} + 64'((gdata - glo_r) >> 1);
      div_req.divisor  = {1'b0, gdata - glo_r};
    end
  end

  byti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (take && (q_cmd.kind == KIND_LOOKUP)) state_nxt = S_G0;
      S_G0:    state_nxt = S_GN;
      S_GN:    state_nxt = S_CHK;
      S_CHK: begin
        if (fin_valid) state_nxt = gsel_r ? S_WGT : S_G0;
        else state_nxt = S_SRCH;
      end
      S_SRCH:  state_nxt = (a_r < b_r) ? S_SCMP : S_RLO;
      S_SCMP:  state_nxt = S_SRCH;
      S_RLO:   state_nxt = S_RHI;
      S_RHI:   state_nxt = S_FRAC;
      S_FRAC: begin
        if (fin_valid) state_nxt = gsel_r ? S_WGT : S_G0;
        else state_nxt = S_FDIV;
      end
      S_FDIV:  if (fin_valid) state_nxt = gsel_r ? S_WGT : S_G0;
      S_WGT:   if (c_r == 3'd4) state_nxt = S_WEND;
      S_WEND:  state_nxt = ((found_r == '0) || (wsum_r == '0)) ? S_EMIT : S_YRD;
      S_YRD: begin
        if (c_r == 3'd4) state_nxt = S_NDIV;
        else if (found_r[c_r[1:0]]) state_nxt = S_YMUL;
      end
      S_YMUL:  state_nxt = S_YADD;
      S_YADD:  state_nxt = S_YRD;
      S_NDIV:  state_nxt = S_NWAIT;
      S_NWAIT: begin
        if (div_rsp.done) state_nxt = (k_r == KW'(YIELD_WORDS - 1)) ? S_EMIT : S_YRD;
      end
      S_EMIT:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take && (q_cmd.kind == KIND_CLEAR)) begin
        present_r <= '0;
      end else if (y_we) begin
        present_r[wcell] <= 1'b1;
      end
      if ((state_r == S_EMIT) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      qm_r   <= q_cmd.query_mass;
      qz_r   <= q_cmd.query_z;
      gsel_r <= 1'b0;
    end
    if (fin_valid) begin
      gsel_r <= !gsel_r;
      if (gsel_r) begin
        zlo_r <= fin_lo;
        zhi_r <= fin_hi;
        zf_r  <= fin_f;
        zr_r  <= fin_rng;
        c_r    <= '0;
        wsum_r <= '0;
      end else begin
        mlo_r <= fin_lo;
        mhi_r <= fin_hi;
        mf_r  <= fin_f;
        mr_r  <= fin_rng;
      end
    end
    case (state_r)
      S_GN:  g0_r <= gdata;
      S_CHK: begin
        a_r <= '0;
        b_r <= n_cur;
      end
      S_SRCH: begin
        mid_r <= mid;
        if (a_r >= b_r) begin
          if (a_r == '0) a_r <= SW'(1);
          else if (a_r > n_cur - SW'(1)) a_r <= n_cur - SW'(1);
        end
      end
      S_SCMP: begin
        if (gdata < q_cur) a_r <= mid_r + SW'(1);
        else b_r <= mid_r;
      end
      S_RHI: glo_r <= gdata;
      S_WGT: begin
        if (c_r != 3'd4) begin
          w_r[c_r[1:0]]     <= 33'(wprod);
          found_r[c_r[1:0]] <= cfound;
        end
        if ((c_r != '0) && found_r[2'(c_r - 3'd1)]) begin
          wsum_r <= wsum_r + w_r[2'(c_r - 3'd1)];
        end
        c_r <= c_r + 3'd1;
      end
      S_WEND: begin
        c_r   <= '0;
        k_r   <= '0;
        acc_r <= '0;
        if ((found_r == '0) || (wsum_r == '0)) begin
          for (int i = 0; i < YIELD_WORDS; i++) words_r[i] <= '0;
        end
      end
      S_YRD: begin
        if ((c_r != 3'd4) && !found_r[c_r[1:0]]) c_r <= c_r + 3'd1;
      end
      S_YMUL: prod_r <= $signed({1'b0, w_r[c_r[1:0]]}) * $signed(y_rdata);
      S_YADD: begin
        acc_r <= acc_r + prod_r;
        c_r   <= c_r + 3'd1;
      end
      S_NDIV: neg_r <= acc_r[65];
      S_NWAIT: begin
        if (div_rsp.done) begin
          words_r[k_r] <= neg_r ? 32'(-div_rsp.quotient) : 32'(div_rsp.quotient);
          k_r   <= k_r + KW'(1);
          c_r   <= '0;
          acc_r <= '0;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_words_r <= words_r;
          out_nm_r    <= (found_r == '0);
          out_mr_r    <= mr_r;
          out_zr_r    <= zr_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.start_time      = out_words_r[0];
  assign out_ch.end_time        = out_words_r[1];
  assign out_ch.carbon_yield    = out_words_r[2];
  assign out_ch.nitrogen_yield  = out_words_r[3];
  assign out_ch.oxygen_yield    = out_words_r[4];
  assign out_ch.neon_yield      = out_words_r[5];
  assign out_ch.magnesium_yield = out_words_r[6];
  assign out_ch.metal_yield     = out_words_r[7];
  assign out_ch.lost_mass       = out_words_r[8];
  assign out_ch.no_match        = out_nm_r;
  assign out_ch.mass_range      = out_mr_r;
  assign out_ch.z_range         = out_zr_r;

endmodule

@@ rtl/bilinear_yield_table_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_yield_table_interpolator_core
// two-dimensional yield table with bilinear lookup over present cells
// ----------------------------------------------------------------------------
// in_ch carries load and lookup items, out_ch one result per lookup; both
// are valid/ready channels. grid writes, yield writes and presence clears
// return nothing. cfg_we/cfg_index/cfg_data set the point counts in use.
// items pass a two-entry queue, so the input keeps taking items until the
// queue is full while the sequencer works or a result waits on the output
// register. a write is done in the same cycle that it leaves the queue.
// a lookup holds the sequencer for two bracket searches over the grid
// memories, each a binary search unless the query lies at or beyond an end
// point and each followed by a fraction divide when the query falls strictly
// between two points, then per yield word up to four corner reads with a
// multiply-accumulate and a normalizing divide; the one-bit-per-cycle divider
// sets most of the lookup time. lookups run one at a time. reset clears the
// presence map, the queue and output valid and sets both point counts to
// one; grid and yield memories keep their contents. a stalled receiver
// holds the result, and the sequencer then waits before loading the next one.
// ----------------------------------------------------------------------------
module bilinear_yield_table_interpolator_core
  import byti_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  byti_in_if.sink           in_ch,
  byti_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  logic [4:0] mass_used_r;
  logic [3:0] z_used_r;
  logic       q_full, q_push, q_pop, q_valid;
  cmd_t       push_cmd, pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_used_r <= 5'd1;
      z_used_r    <= 4'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_MASS_USED) mass_used_r <= cfg_data;
      if (cfg_index == REG_Z_USED) z_used_r <= cfg_data[3:0];
    end
  end

  byti_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  byti_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  byti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mass_used (mass_used_r),
    .z_used    (z_used_r),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/byti_checker.sv @@
// ----------------------------------------------------------------------------
// byti_checker
// port-level checks of the result channel, bound to the core
// ----------------------------------------------------------------------------
`include "bilinear_yield_table_interpolator_core_assert.svh"

module byti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] start_time,
  input logic [31:0] end_time,
  input logic [31:0] lost_mass,
  input logic        no_match,
  input logic [1:0]  mass_range,
  input logic [1:0]  z_range
);

  `BYTI_ASSERT_RESET(a_reset_idle, clk, rst_n, !out_valid)

  `BYTI_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(start_time) && $stable(no_match))

  `BYTI_ASSERT_SAME(a_nomatch_zero, clk, rst_n, out_valid && no_match, (start_time == 32'd0) && (end_time == 32'd0) && (lost_mass == 32'd0))

  `BYTI_ASSERT_SAME(a_range_code, clk, rst_n, out_valid, (mass_range != 2'd3) && (z_range != 2'd3))

endmodule

bind bilinear_yield_table_interpolator_core byti_checker u_byti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .start_time (out_ch.start_time),
  .end_time   (out_ch.end_time),
  .lost_mass  (out_ch.lost_mass),
  .no_match   (out_ch.no_match),
  .mass_range (out_ch.mass_range),
  .z_range    (out_ch.z_range)
);
